@@ src/darl_pkg.sv @@
// Shared types and constants for the door access relay/lockout block.
// No dependencies; used by every module in src and by the checker.
`default_nettype none

package darl_pkg;

    localparam int unsigned ATTEMPT_LEVELS = 13;
    localparam int unsigned LEVEL_W        = 4;
    localparam int unsigned PENALTY_W      = 7;
    localparam int unsigned MS_W           = 16;
    localparam int unsigned UNIT_W         = 12;
    localparam int unsigned LOCK_W         = 19;
    localparam int unsigned CFG_ADDR_W     = 3;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(ATTEMPT_LEVELS - 1);

    // reset values of the configuration registers
    localparam logic [MS_W-1:0]   RELAY_ONE_RST = MS_W'(1000);
    localparam logic [MS_W-1:0]   RELAY_TWO_RST = MS_W'(1000);
    localparam logic [MS_W-1:0]   PROMPT_RST    = MS_W'(10000);
    localparam logic [MS_W-1:0]   PEN_BASE_RST  = MS_W'(3000);
    localparam logic [UNIT_W-1:0] PEN_UNIT_RST  = UNIT_W'(1000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RELAY_ONE = 3'd0,
        CFG_RELAY_TWO = 3'd1,
        CFG_PROMPT    = 3'd2,
        CFG_PEN_BASE  = 3'd3,
        CFG_PEN_UNIT  = 3'd4
    } t_cfg_addr;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_CARD = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        SND_NONE     = 3'd0,
        SND_WAITING  = 3'd1,
        SND_ACCEPTED = 3'd2,
        SND_DENIED_1 = 3'd3,
        SND_DENIED_2 = 3'd4,
        SND_DENIED_N = 3'd5
    } t_sound;

    typedef logic [PENALTY_W-1:0] t_pen_table [ATTEMPT_LEVELS];

    localparam t_pen_table PENALTY_TABLE = '{
        7'd1, 7'd3, 7'd4, 7'd5, 7'd8, 7'd12, 7'd17,
        7'd23, 7'd30, 7'd38, 7'd47, 7'd57, 7'd68
    };

    function automatic logic [PENALTY_W-1:0] penalty_entry(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] idx;
        idx = (level > MAX_LEVEL) ? MAX_LEVEL : level;
        return PENALTY_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

@@ src/darl_penalty.sv @@
// Lockout length for an invalid card: base + table[level] * unit.
// Depends on darl_pkg.
`default_nettype none

module darl_penalty (
    input  wire logic [darl_pkg::LEVEL_W-1:0] i_level,
    input  wire logic [darl_pkg::MS_W-1:0]    i_base,
    input  wire logic [darl_pkg::UNIT_W-1:0]  i_unit,
    output logic      [darl_pkg::LOCK_W-1:0]  o_lockout
);

    logic [darl_pkg::PENALTY_W-1:0] entry;
    logic [darl_pkg::LOCK_W-1:0]    prod;

    always_comb begin
        entry     = darl_pkg::penalty_entry(i_level);
        prod      = darl_pkg::LOCK_W'(entry) * darl_pkg::LOCK_W'(i_unit);
        o_lockout = prod + darl_pkg::LOCK_W'(i_base);
    end

endmodule

`default_nettype wire

@@ src/door_access_relay_lockout.sv @@
// Top level of the door access controller: relay sequencing, penalty lockout,
// waiting prompt. Depends on darl_pkg and darl_penalty.
//
//  channel  | direction | tdata (lsb up)                          | tuser
//  s_axis   | in        | card_valid, pad to 8                    | command
//  m_axis   | out       | relay_one_on, relay_two_on,             | -
//           |           | sound_request[2:0], locked_out,         |
//           |           | card_ignored, attempt_level[3:0], pad   |
//  cfg      | in        | i_cfg_addr selects, i_cfg_wdata[15:0]   | -
//
// One beat per cycle unless stalled; results show the cycle after the beat.
// State updates and the result register load in the same single pass.
// s_axis_tready is low only while a result waits and m_axis_tready is low.
// Synchronous active-low reset restores register defaults and idle state.
`default_nettype none

module door_access_relay_lockout (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [darl_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [darl_pkg::MS_W-1:0]         i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // card_valid
    input  wire logic                              s_axis_tuser,  // command
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // relay_one_on, relay_two_on, sound_request[2:0], locked_out,
    // card_ignored, attempt_level[3:0]
    output logic      [15:0]                       m_axis_tdata
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } t_phase;

    localparam int unsigned MS_W = darl_pkg::MS_W;

    logic [MS_W-1:0]                 r_relay_one, r_relay_two, r_prompt, r_pen_base;
    logic [darl_pkg::UNIT_W-1:0]     r_pen_unit;

    t_phase                          r_phase, n_phase;
    logic [MS_W-1:0]                 r_elapsed, n_elapsed;
    logic [darl_pkg::LEVEL_W-1:0]    r_level, n_level;
    logic [darl_pkg::LOCK_W-1:0]     r_lock, n_lock;
    logic [MS_W-1:0]                 r_uptime, n_uptime;
    logic                            r_card_seen, n_card_seen;
    logic                            r_prompt_given, n_prompt_given;

    logic                            r_m_valid;
    logic [15:0]                     r_m_data, n_m_data;

    logic [darl_pkg::LOCK_W-1:0]     penalty;
    logic [MS_W-1:0]                 elapsed_inc;
    darl_pkg::t_sound                sound;
    logic                            ignored;
    logic                            accept;

    darl_penalty u_penalty (
        .i_level   (r_level),
        .i_base    (r_pen_base),
        .i_unit    (r_pen_unit),
        .o_lockout (penalty)
    );

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        n_phase        = r_phase;
        n_elapsed      = r_elapsed;
        n_level        = r_level;
        n_lock         = r_lock;
        n_uptime       = r_uptime;
        n_card_seen    = r_card_seen;
        n_prompt_given = r_prompt_given;
        sound          = darl_pkg::SND_NONE;
        ignored        = 1'b0;
        elapsed_inc    = (r_elapsed != '1) ? r_elapsed + MS_W'(1) : r_elapsed;

        if (darl_pkg::t_cmd'(s_axis_tuser) == darl_pkg::CMD_TICK) begin
            if (r_uptime != '1) begin
                n_uptime = r_uptime + MS_W'(1);
            end
            if (r_lock != '0) begin
                n_lock = r_lock - darl_pkg::LOCK_W'(1);
            end
            case (r_phase)
                PH_ONE: begin
                    if (elapsed_inc >= r_relay_one) begin
                        n_phase   = PH_TWO;
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
                PH_TWO: begin
                    if (elapsed_inc >= r_relay_two) begin
                        n_phase   = PH_IDLE;
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
                default: ;
            endcase
            if (n_uptime > r_prompt && !r_prompt_given && !r_card_seen) begin
                sound          = darl_pkg::SND_WAITING;
                n_prompt_given = 1'b1;
            end
        end else if (r_lock != '0) begin
            ignored = 1'b1;
        end else begin
            n_card_seen = 1'b1;
            if (s_axis_tdata[0]) begin
                n_level   = '0;
                sound     = darl_pkg::SND_ACCEPTED;
                n_phase   = PH_ONE;
                n_elapsed = '0;
            end else begin
                if (r_level == darl_pkg::LEVEL_W'(0)) begin
                    sound = darl_pkg::SND_DENIED_1;
                end else if (r_level == darl_pkg::LEVEL_W'(1)) begin
                    sound = darl_pkg::SND_DENIED_2;
                end else begin
                    sound = darl_pkg::SND_DENIED_N;
                end
                n_lock = penalty;
                if (r_level < darl_pkg::MAX_LEVEL) begin
                    n_level = r_level + darl_pkg::LEVEL_W'(1);
                end
            end
        end

        n_m_data = {5'b0, n_level, ignored, (n_lock != '0), sound,
                    (n_phase == PH_TWO), (n_phase == PH_ONE)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_one    <= darl_pkg::RELAY_ONE_RST;
            r_relay_two    <= darl_pkg::RELAY_TWO_RST;
            r_prompt       <= darl_pkg::PROMPT_RST;
            r_pen_base     <= darl_pkg::PEN_BASE_RST;
            r_pen_unit     <= darl_pkg::PEN_UNIT_RST;
            r_phase        <= PH_IDLE;
            r_elapsed      <= '0;
            r_level        <= '0;
            r_lock         <= '0;
            r_uptime       <= '0;
            r_card_seen    <= 1'b0;
            r_prompt_given <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (darl_pkg::t_cfg_addr'(i_cfg_addr))
                    darl_pkg::CFG_RELAY_ONE: r_relay_one <= i_cfg_wdata;
                    darl_pkg::CFG_RELAY_TWO: r_relay_two <= i_cfg_wdata;
                    darl_pkg::CFG_PROMPT:    r_prompt    <= i_cfg_wdata;
                    darl_pkg::CFG_PEN_BASE:  r_pen_base  <= i_cfg_wdata;
                    darl_pkg::CFG_PEN_UNIT:
                        r_pen_unit <= i_cfg_wdata[darl_pkg::UNIT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase        <= n_phase;
                r_elapsed      <= n_elapsed;
                r_level        <= n_level;
                r_lock         <= n_lock;
                r_uptime       <= n_uptime;
                r_card_seen    <= n_card_seen;
                r_prompt_given <= n_prompt_given;
                r_m_valid      <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= n_m_data;
        end
    end

endmodule

`default_nettype wire

@@ src/darl_checker.sv @@
// Port-level checker for door_access_relay_lockout, attached by bind.
// Depends on darl_pkg.
`default_nettype none

module darl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("both relays driven");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |->
            m_axis_tdata[5] && m_axis_tdata[4:2] == darl_pkg::SND_NONE)
        else $error("dropped card without lockout or with sound");

    a_sound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:2] <= darl_pkg::SND_DENIED_N
            && m_axis_tdata[10:7] <= darl_pkg::MAX_LEVEL)
        else $error("sound or level out of range");

    a_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4:2] == darl_pkg::SND_ACCEPTED |->
            m_axis_tdata[0] && m_axis_tdata[10:7] == 4'd0)
        else $error("accepted card without relay one and cleared level");

endmodule

bind door_access_relay_lockout darl_checker u_darl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/door_access_relay_lockout_tb.sv @@
// Self-checking testbench for door_access_relay_lockout: directed table, then random
// phases under several timing settings, every result compared against a typed row or a cycle-free predictor.
// Depends on src/darl_pkg.sv and src/door_access_relay_lockout.sv.

module door_access_relay_lockout_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF     = 5;
    localparam int  HOLD_AT      = 720;
    localparam int  HOLD_LEN     = 150;
    localparam int  IDLE_PCT     = 33;
    localparam longint RUN_LIMIT = 15_000_000;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } t_relay_phase;

    // lsb up: relay_one, relay_two, sound, locked, ignored, level
    typedef struct packed {
        logic [darl_pkg::LEVEL_W-1:0] level;
        logic                         ignored;
        logic                         locked;
        darl_pkg::t_sound             sound;
        logic                         relay_two;
        logic                         relay_one;
    } t_door_out;

    typedef struct packed {
        darl_pkg::t_cmd cmd;
        logic           card_ok;
        logic           typed;
        t_door_out      want;
    } t_row;

    localparam int LOCK_STEPS [darl_pkg::ATTEMPT_LEVELS] =
        '{1, 3, 4, 5, 8, 12, 17, 23, 30, 38, 47, 57, 68};

    localparam t_door_out QUIET  = '0;
    localparam t_door_out PROMPT = '{4'd0, 1'b0, 1'b0, darl_pkg::SND_WAITING,  1'b0, 1'b0};
    localparam t_door_out OPEN   = '{4'd0, 1'b0, 1'b0, darl_pkg::SND_ACCEPTED, 1'b0, 1'b1};
    localparam t_door_out DENY1  = '{4'd1, 1'b0, 1'b1, darl_pkg::SND_DENIED_1, 1'b0, 1'b0};
    localparam t_door_out DROP1  = '{4'd1, 1'b1, 1'b1, darl_pkg::SND_NONE,     1'b0, 1'b0};

    // timing during the table: prompt 3, relay one 2, relay two 1, base 2, unit 0
    localparam t_row DIRECTED [24] = '{
        '{darl_pkg::CMD_TICK, 1'b0, 1'b1, QUIET},
        '{darl_pkg::CMD_TICK, 1'b1, 1'b1, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b1, QUIET},
        '{darl_pkg::CMD_TICK, 1'b1, 1'b1, PROMPT},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b1, QUIET},
        '{darl_pkg::CMD_CARD, 1'b1, 1'b1, OPEN},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b1, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_CARD, 1'b0, 1'b1, DENY1},
        '{darl_pkg::CMD_CARD, 1'b1, 1'b1, DROP1},
        '{darl_pkg::CMD_CARD, 1'b0, 1'b1, DROP1},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b1, 1'b0, QUIET},
        '{darl_pkg::CMD_CARD, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_CARD, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b1, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_CARD, 1'b1, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET},
        '{darl_pkg::CMD_CARD, 1'b1, 1'b0, QUIET},
        '{darl_pkg::CMD_TICK, 1'b0, 1'b0, QUIET}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [darl_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [darl_pkg::MS_W-1:0]       i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;   // card_valid, pad
    logic                            s_axis_tuser;   // command
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // relay_one_on, relay_two_on, sound_request[2:0], locked_out,
    // card_ignored, attempt_level[3:0], pad
    logic [15:0]                     m_axis_tdata;

    door_access_relay_lockout u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [darl_pkg::MS_W-1:0]    cfg_one    = darl_pkg::RELAY_ONE_RST;
    logic [darl_pkg::MS_W-1:0]    cfg_two    = darl_pkg::RELAY_TWO_RST;
    logic [darl_pkg::MS_W-1:0]    cfg_prompt = darl_pkg::PROMPT_RST;
    logic [darl_pkg::MS_W-1:0]    cfg_base   = darl_pkg::PEN_BASE_RST;
    logic [darl_pkg::UNIT_W-1:0]  cfg_unit   = darl_pkg::PEN_UNIT_RST;
    t_relay_phase                 phase      = PH_IDLE;
    logic [darl_pkg::MS_W-1:0]    elapsed    = '0;
    logic [darl_pkg::LEVEL_W-1:0] level      = '0;
    logic [darl_pkg::LOCK_W-1:0]  lock_left  = '0;
    logic [darl_pkg::MS_W-1:0]    up_ms      = '0;
    logic                         card_seen  = 1'b0;
    logic                         prompted   = 1'b0;

    t_door_out outputs_due [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    bit        no_idle      = 1'b0;

    function automatic t_door_out door_step(input darl_pkg::t_cmd cmd, input logic card_ok);
        t_door_out                    r;
        logic [darl_pkg::LEVEL_W-1:0] idx;
        r = '0;
        if (cmd == darl_pkg::CMD_TICK) begin
            if (up_ms != '1) up_ms++;
            if (lock_left != '0) lock_left--;
            if (phase != PH_IDLE) begin
                if (elapsed != '1) elapsed++;
                if (phase == PH_ONE && elapsed >= cfg_one) begin
                    phase   = PH_TWO;
                    elapsed = '0;
                end else if (phase == PH_TWO && elapsed >= cfg_two) begin
                    phase   = PH_IDLE;
                    elapsed = '0;
                end
            end
            if (up_ms > cfg_prompt && !prompted && !card_seen) begin
                r.sound  = darl_pkg::SND_WAITING;
                prompted = 1'b1;
            end
        end else if (lock_left != '0) begin
            r.ignored = 1'b1;
        end else begin
            card_seen = 1'b1;
            if (card_ok) begin
                level   = '0;
                r.sound = darl_pkg::SND_ACCEPTED;
                phase   = PH_ONE;
                elapsed = '0;
            end else begin
                r.sound = (level == 0) ? darl_pkg::SND_DENIED_1 :
                          (level == 1) ? darl_pkg::SND_DENIED_2 : darl_pkg::SND_DENIED_N;
                idx = (level > darl_pkg::MAX_LEVEL) ? darl_pkg::MAX_LEVEL : level;
                lock_left = darl_pkg::LOCK_W'(cfg_base)
                          + darl_pkg::LOCK_W'(LOCK_STEPS[idx]) * darl_pkg::LOCK_W'(cfg_unit);
                if (level < darl_pkg::MAX_LEVEL) level++;
            end
        end
        r.relay_one = (phase == PH_ONE);
        r.relay_two = (phase == PH_TWO);
        r.locked    = (lock_left != '0);
        r.level     = level;
        return r;
    endfunction

    task automatic send_item(input darl_pkg::t_cmd cmd, input logic card_ok,
                             input logic typed, input t_door_out want);
        t_door_out predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, card_ok};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = door_step(cmd, card_ok);
        outputs_due.push_back(typed ? want : predicted);
    endtask

    task automatic send_tick();
        send_item(darl_pkg::CMD_TICK, 1'($urandom_range(1)), 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outputs_due.size() != 0);
    endtask

    task automatic cfg_write(input logic [darl_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [darl_pkg::MS_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (darl_pkg::t_cfg_addr'(addr))
            darl_pkg::CFG_RELAY_ONE: cfg_one    = data;
            darl_pkg::CFG_RELAY_TWO: cfg_two    = data;
            darl_pkg::CFG_PROMPT:    cfg_prompt = data;
            darl_pkg::CFG_PEN_BASE:  cfg_base   = data;
            darl_pkg::CFG_PEN_UNIT:  cfg_unit   = data[darl_pkg::UNIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [darl_pkg::MS_W-1:0] one,
                              input logic [darl_pkg::MS_W-1:0] two,
                              input logic [darl_pkg::MS_W-1:0] prompt,
                              input logic [darl_pkg::MS_W-1:0] base,
                              input logic [darl_pkg::MS_W-1:0] unit);
        wait_drained();
        cfg_write(darl_pkg::CFG_RELAY_ONE, one);
        cfg_write(darl_pkg::CFG_RELAY_TWO, two);
        cfg_write(darl_pkg::CFG_PROMPT, prompt);
        cfg_write(darl_pkg::CFG_PEN_BASE, base);
        cfg_write(darl_pkg::CFG_PEN_UNIT, unit);
        // unmapped index, must be dropped
        cfg_write(darl_pkg::CFG_ADDR_W'($urandom_range(2 ** darl_pkg::CFG_ADDR_W - 1,
                                                       int'(darl_pkg::CFG_PEN_UNIT) + 1)),
                  darl_pkg::MS_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n, input int card_pct, input int valid_pct,
                              input bit pressure);
        int   k;
        bit   is_card;
        logic card_ok;
        for (k = 0; k < n; k++) begin
            if (pressure && k == n / 3) no_idle = 1'b1;
            if (pressure && k == 2 * n / 3) begin
                no_idle = 1'b0;
                wait_drained();
            end
            is_card = ($urandom_range(99) < card_pct);
            card_ok = is_card ? ($urandom_range(99) < valid_pct) : 1'($urandom_range(1));
            send_item(is_card ? darl_pkg::CMD_CARD : darl_pkg::CMD_TICK, card_ok, 1'b0, '0);
        end
    endtask

    task automatic check_result(input t_door_out got);
        t_door_out want;
        if (outputs_due.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            mismatches++;
        end else begin
            want = outputs_due.pop_front();
            if (got.relay_one !== want.relay_one) begin
                $error("relay_one_on: expected %0d, got %0d", want.relay_one, got.relay_one);
                mismatches++;
            end
            if (got.relay_two !== want.relay_two) begin
                $error("relay_two_on: expected %0d, got %0d", want.relay_two, got.relay_two);
                mismatches++;
            end
            if (got.sound !== want.sound) begin
                $error("sound_request: expected %0d, got %0d", want.sound, got.sound);
                mismatches++;
            end
            if (got.locked !== want.locked) begin
                $error("locked_out: expected %0d, got %0d", want.locked, got.locked);
                mismatches++;
            end
            if (got.ignored !== want.ignored) begin
                $error("card_ignored: expected %0d, got %0d", want.ignored, got.ignored);
                mismatches++;
            end
            if (got.level !== want.level) begin
                $error("attempt_level: expected %0d, got %0d", want.level, got.level);
                mismatches++;
            end
        end
        results_seen++;
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(t_door_out'(m_axis_tdata[10:0]));
                if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
            end
            if (!i_rst_n || hold_left > 0) begin
                if (hold_left > 0) hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int k;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= darl_pkg::CMD_TICK;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_timing(16'd2, 16'd1, 16'd3, 16'd2, 16'd0);
        for (k = 0; k < $size(DIRECTED); k++)
            send_item(DIRECTED[k].cmd, DIRECTED[k].card_ok, DIRECTED[k].typed, DIRECTED[k].want);

        // no lockout at all, shortest relay phases
        set_timing(16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd0);
        run_random(200, 40, 50, 1'b0);

        // relay phase registers set to zero
        set_timing(16'd0, 16'd0, 16'd0, 16'd5, 16'd1);
        run_random(150, 30, 50, 1'b0);

        // rare valid cards: attempt level climbs to saturation
        set_timing(darl_pkg::MS_W'($urandom_range(8, 1)), darl_pkg::MS_W'($urandom_range(8, 1)),
                   darl_pkg::MS_W'($urandom), darl_pkg::MS_W'($urandom_range(4)), 16'd1);
        run_random(300, 30, 5, 1'b0);

        set_timing(darl_pkg::MS_W'($urandom_range(20, 1)), darl_pkg::MS_W'($urandom_range(20, 1)),
                   darl_pkg::MS_W'($urandom), darl_pkg::MS_W'($urandom_range(10)),
                   darl_pkg::MS_W'($urandom_range(3)));
        run_random(300, 25, 40, 1'b1);

        // largest register values; unit write carries bits above its width
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(200, 20, 100, 1'b0);
        while (lock_left != '0) send_tick();
        send_item(darl_pkg::CMD_CARD, 1'b1, 1'b0, '0);
        // lockout from attempt level zero at the largest register values; the cards after it are dropped
        send_item(darl_pkg::CMD_CARD, 1'b0, 1'b0, '0);
        for (k = 0; k < 3; k++) send_item(darl_pkg::CMD_CARD, 1'($urandom_range(1)), 1'b0, '0);
        send_tick();

        wait_drained();
        repeat (3) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
